/* sv/vmt_pkg.sv */
// ----------------------------------------------------------------------------
// vmt_pkg
// Shared types and constants for the 4x4 vector matrix transform engine.
// ----------------------------------------------------------------------------
package vmt_pkg;

   localparam int WORD_W    = 32;
   localparam int VEC_N     = 4;
   localparam int ROW_W     = 2;
   localparam int PROD_W    = 2 * WORD_W;
   localparam int PAIR_W    = PROD_W + 1;
   localparam int SUM_W     = PROD_W + 2;
   localparam int FRAC_BITS = 16;

   localparam logic OP_LOAD      = 1'b0;
   localparam logic OP_TRANSFORM = 1'b1;

   typedef logic signed [WORD_W-1:0] vmt_word_type;
   typedef logic signed [PROD_W-1:0] vmt_prod_type;
   typedef logic signed [PAIR_W-1:0] vmt_pair_type;
   typedef logic signed [SUM_W-1:0]  vmt_sum_type;

   typedef struct packed {
      logic                     operation;
      logic [ROW_W-1:0]         row_index;
      logic signed [WORD_W-1:0] comp_0;
      logic signed [WORD_W-1:0] comp_1;
      logic signed [WORD_W-1:0] comp_2;
      logic signed [WORD_W-1:0] comp_3;
   } vmt_req_type;

   typedef struct packed {
      logic signed [WORD_W-1:0] res_0;
      logic signed [WORD_W-1:0] res_1;
      logic signed [WORD_W-1:0] res_2;
      logic signed [WORD_W-1:0] res_3;
      logic                     saturated;
   } vmt_rsp_type;

endpackage

/* sv/vector_matrix_transform.sv */
// ----------------------------------------------------------------------------
// vector_matrix_transform
// 4x4 row-vector transform engine in signed fixed point.
//
// A request on the req_ channel either loads one matrix row (operation 0,
// row_index selects the row) or transforms a row vector (operation 1).
// A load gives no response. A transform gives one response on the rsp_
// channel: res_j = sum over i of comp_i * M[i][j], shifted right by
// FRAC_BITS with rounding toward minus infinity and saturated to 32 bits.
// The saturated bit is set when any component was clipped.
// The pipeline has five register stages: input, products, pair sums,
// final sum with shift, and saturation. One request is accepted every
// cycle while req_stall is low. A transform sees every load accepted
// before it. Reset clears the matrix to zero and empties the pipeline.
// When the receiver raises rsp_stall, the stages fill up behind the held
// response and req_stall rises once the input stage cannot move.
// ----------------------------------------------------------------------------
module vector_matrix_transform #(
   parameter int FRAC_BITS = vmt_pkg::FRAC_BITS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  vmt_pkg::vmt_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output vmt_pkg::vmt_rsp_type rsp_data
);

   localparam int SHIFT_W = vmt_pkg::SUM_W - FRAC_BITS;

   vmt_pkg::vmt_req_type      in_ff;
   logic                      in_valid_ff;
   logic                      in_ready;
   logic                      mat_ready;
   logic                      prod_valid;
   logic                      red_ready;
   vmt_pkg::vmt_prod_type     prod [vmt_pkg::VEC_N][vmt_pkg::VEC_N];
   logic                      shift_valid;
   logic                      clip_ready;
   logic signed [SHIFT_W-1:0] shift [vmt_pkg::VEC_N];

   assign in_ready  = !in_valid_ff || mat_ready;
   assign req_stall = !in_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (in_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         in_ff <= req_data;
      end
   end

   vmt_matrix u_matrix (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (in_valid_ff),
      .in_ready  (mat_ready),
      .in_data   (in_ff),
      .out_valid (prod_valid),
      .out_ready (red_ready),
      .out_prod  (prod)
   );

   vmt_reduce #(
      .FRAC_BITS (FRAC_BITS)
   ) u_reduce (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (prod_valid),
      .in_ready  (red_ready),
      .in_prod   (prod),
      .out_valid (shift_valid),
      .out_ready (clip_ready),
      .out_shift (shift)
   );

   vmt_clip #(
      .FRAC_BITS (FRAC_BITS)
   ) u_clip (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (shift_valid),
      .in_ready  (clip_ready),
      .in_shift  (shift),
      .out_valid (rsp_valid),
      .out_ready (!rsp_stall),
      .out_data  (rsp_data)
   );

endmodule

/* sv/vmt_matrix.sv */
// ----------------------------------------------------------------------------
// vmt_matrix
// Matrix row store and the product stage: sixteen exact 32x32 products.
// ----------------------------------------------------------------------------
module vmt_matrix (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  vmt_pkg::vmt_req_type in_data,
   output logic                 out_valid,
   input  logic                 out_ready,
   output vmt_pkg::vmt_prod_type out_prod [vmt_pkg::VEC_N][vmt_pkg::VEC_N]
);

   vmt_pkg::vmt_word_type matrix_ff [vmt_pkg::VEC_N][vmt_pkg::VEC_N];
   vmt_pkg::vmt_word_type vec      [vmt_pkg::VEC_N];
   vmt_pkg::vmt_prod_type prod_in  [vmt_pkg::VEC_N][vmt_pkg::VEC_N];
   vmt_pkg::vmt_prod_type prod_ff  [vmt_pkg::VEC_N][vmt_pkg::VEC_N];
   logic                  valid_ff;
   logic                  valid_in;
   logic                  take;

   assign vec[0] = in_data.comp_0;
   assign vec[1] = in_data.comp_1;
   assign vec[2] = in_data.comp_2;
   assign vec[3] = in_data.comp_3;

   assign in_ready = !valid_ff || out_ready;
   assign take     = in_valid && in_ready;
   assign valid_in = take && (in_data.operation == vmt_pkg::OP_TRANSFORM);

   always_comb begin
      for (int i = 0; i < vmt_pkg::VEC_N; i++) begin
         for (int j = 0; j < vmt_pkg::VEC_N; j++) begin
            prod_in[i][j] = vmt_pkg::vmt_prod_type'(vec[i])
                          * vmt_pkg::vmt_prod_type'(matrix_ff[i][j]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < vmt_pkg::VEC_N; i++) begin
            for (int j = 0; j < vmt_pkg::VEC_N; j++) begin
               matrix_ff[i][j] <= '0;
            end
         end
      end else if (take && (in_data.operation == vmt_pkg::OP_LOAD)) begin
         for (int j = 0; j < vmt_pkg::VEC_N; j++) begin
            matrix_ff[in_data.row_index][j] <= vec[j];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         prod_ff <= prod_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_prod  = prod_ff;

endmodule

/* sv/vmt_reduce.sv */
// ----------------------------------------------------------------------------
// vmt_reduce
// Two-stage adder tree per column, then the arithmetic shift by FRAC_BITS.
// ----------------------------------------------------------------------------
module vmt_reduce #(
   parameter  int FRAC_BITS = vmt_pkg::FRAC_BITS,
   localparam int SHIFT_W   = vmt_pkg::SUM_W - FRAC_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  vmt_pkg::vmt_prod_type in_prod [vmt_pkg::VEC_N][vmt_pkg::VEC_N],
   output logic                  out_valid,
   input  logic                  out_ready,
   output logic signed [SHIFT_W-1:0] out_shift [vmt_pkg::VEC_N]
);

   vmt_pkg::vmt_pair_type     pair_in   [vmt_pkg::VEC_N][2];
   vmt_pkg::vmt_pair_type     pair_ff   [vmt_pkg::VEC_N][2];
   vmt_pkg::vmt_sum_type      sum_in    [vmt_pkg::VEC_N];
   logic signed [SHIFT_W-1:0] shift_in  [vmt_pkg::VEC_N];
   logic signed [SHIFT_W-1:0] shift_ff  [vmt_pkg::VEC_N];
   logic                      pair_valid_ff;
   logic                      shift_valid_ff;
   logic                      pair_ready;

   assign in_ready   = !pair_valid_ff || pair_ready;
   assign pair_ready = !shift_valid_ff || out_ready;

   always_comb begin
      for (int j = 0; j < vmt_pkg::VEC_N; j++) begin
         pair_in[j][0] = vmt_pkg::vmt_pair_type'(in_prod[0][j])
                       + vmt_pkg::vmt_pair_type'(in_prod[1][j]);
         pair_in[j][1] = vmt_pkg::vmt_pair_type'(in_prod[2][j])
                       + vmt_pkg::vmt_pair_type'(in_prod[3][j]);
         sum_in[j]     = vmt_pkg::vmt_sum_type'(pair_ff[j][0])
                       + vmt_pkg::vmt_sum_type'(pair_ff[j][1]);
         shift_in[j]   = sum_in[j][vmt_pkg::SUM_W-1:FRAC_BITS];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pair_valid_ff  <= 1'b0;
         shift_valid_ff <= 1'b0;
      end else begin
         if (in_ready) begin
            pair_valid_ff <= in_valid;
         end
         if (pair_ready) begin
            shift_valid_ff <= pair_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         pair_ff <= pair_in;
      end
      if (pair_ready) begin
         shift_ff <= shift_in;
      end
   end

   assign out_valid = shift_valid_ff;
   assign out_shift = shift_ff;

endmodule

/* sv/vmt_clip.sv */
// ----------------------------------------------------------------------------
// vmt_clip
// Saturation to the signed 32-bit range and the response register.
// ----------------------------------------------------------------------------
module vmt_clip #(
   parameter  int FRAC_BITS = vmt_pkg::FRAC_BITS,
   localparam int SHIFT_W   = vmt_pkg::SUM_W - FRAC_BITS
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  logic signed [SHIFT_W-1:0] in_shift [vmt_pkg::VEC_N],
   output logic                      out_valid,
   input  logic                      out_ready,
   output vmt_pkg::vmt_rsp_type      out_data
);

   localparam int W = vmt_pkg::WORD_W;

   vmt_pkg::vmt_word_type res_in [vmt_pkg::VEC_N];
   logic [vmt_pkg::VEC_N-1:0] clip;
   logic [SHIFT_W-W:0]        upper;
   vmt_pkg::vmt_rsp_type      rsp_in;
   vmt_pkg::vmt_rsp_type      rsp_ff;
   logic                      valid_ff;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      for (int j = 0; j < vmt_pkg::VEC_N; j++) begin
         upper   = in_shift[j][SHIFT_W-1:W-1];
         clip[j] = !((&upper) || !(|upper));
         if (!clip[j]) begin
            res_in[j] = in_shift[j][W-1:0];
         end else if (in_shift[j][SHIFT_W-1]) begin
            res_in[j] = {1'b1, {(W-1){1'b0}}};
         end else begin
            res_in[j] = {1'b0, {(W-1){1'b1}}};
         end
      end
      rsp_in.res_0     = res_in[0];
      rsp_in.res_1     = res_in[1];
      rsp_in.res_2     = res_in[2];
      rsp_in.res_3     = res_in[3];
      rsp_in.saturated = |clip;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         rsp_ff <= rsp_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = rsp_ff;

endmodule

/* sim/tb_vector_matrix_transform.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_vector_matrix_transform
// Self-checking testbench for the 4x4 row-vector transform engine.
//
// Requests load matrix rows or transform vectors. A local copy of the matrix
// predicts each transform response: exact products, an exact wide sum, a
// floor shift by FRAC_BITS and saturation to 32 bits. Directed cases cover
// the field extremes and saturation. Random streams follow under changing
// sender gaps and receiver stalls. One long receiver hold fills the pipeline.
// ----------------------------------------------------------------------------
module tb_vector_matrix_transform;

   localparam int CYCLE_LIMIT = 200000;
   localparam int ROW_W       = vmt_pkg::ROW_W;
   localparam logic signed [vmt_pkg::SUM_W-1:0] WORD_HI = 66'sh0_7FFF_FFFF;
   localparam logic signed [vmt_pkg::SUM_W-1:0] WORD_LO = -66'sh0_8000_0000;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   vmt_pkg::vmt_req_type req_data = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   vmt_pkg::vmt_rsp_type rsp_data;

   vmt_pkg::vmt_word_type matrix_model [16] = '{default: '0};
   vmt_pkg::vmt_rsp_type  expected_results [$];
   int                    error_count = 0;
   int                    cycle_count = 0;
   int                    send_gap_pct = 0;
   int                    rsp_stall_pct = 0;
   int                    hold_left = 0;

   vector_matrix_transform u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic vmt_pkg::vmt_rsp_type transform_vector(vmt_pkg::vmt_req_type rq);
      vmt_pkg::vmt_word_type               v [4];
      vmt_pkg::vmt_word_type               col [4];
      logic signed [vmt_pkg::SUM_W-1:0]    acc;
      logic signed [vmt_pkg::SUM_W-1:0]    shifted;
      vmt_pkg::vmt_rsp_type                r;
      r = '0;
      v[0] = rq.comp_0;
      v[1] = rq.comp_1;
      v[2] = rq.comp_2;
      v[3] = rq.comp_3;
      for (int j = 0; j < 4; j++) begin
         acc = '0;
         for (int i = 0; i < 4; i++) begin
            acc = acc + (longint'(v[i]) * longint'(matrix_model[i*4+j]));
         end
         shifted = acc >>> vmt_pkg::FRAC_BITS;
         if (shifted > WORD_HI) begin
            col[j] = 32'h7FFF_FFFF;
            r.saturated = 1'b1;
         end else if (shifted < WORD_LO) begin
            col[j] = 32'h8000_0000;
            r.saturated = 1'b1;
         end else begin
            col[j] = shifted[vmt_pkg::WORD_W-1:0];
         end
      end
      r.res_0 = col[0];
      r.res_1 = col[1];
      r.res_2 = col[2];
      r.res_3 = col[3];
      return r;
   endfunction

   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         if (req_data.operation == vmt_pkg::OP_TRANSFORM) begin
            expected_results.push_back(transform_vector(req_data));
         end else begin
            matrix_model[req_data.row_index*4+0] = req_data.comp_0;
            matrix_model[req_data.row_index*4+1] = req_data.comp_1;
            matrix_model[req_data.row_index*4+2] = req_data.comp_2;
            matrix_model[req_data.row_index*4+3] = req_data.comp_3;
         end
      end
   end

   task automatic check_field(input string name,
                              input logic [vmt_pkg::WORD_W-1:0] exp_val,
                              input logic [vmt_pkg::WORD_W-1:0] act_val);
      if (exp_val !== act_val) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_val, act_val);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      vmt_pkg::vmt_rsp_type exp_rsp;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_results.size() == 0) begin
            $display("%0t: unexpected response, expected none, actual %h", $time, rsp_data);
            error_count++;
         end else begin
            exp_rsp = expected_results.pop_front();
            check_field("res_0", exp_rsp.res_0, rsp_data.res_0);
            check_field("res_1", exp_rsp.res_1, rsp_data.res_1);
            check_field("res_2", exp_rsp.res_2, rsp_data.res_2);
            check_field("res_3", exp_rsp.res_3, rsp_data.res_3);
            check_field("saturated", 32'(exp_rsp.saturated), 32'(rsp_data.saturated));
         end
      end
   end

   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left = hold_left - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d responses outstanding", $time,
                  expected_results.size());
         $display("== FAIL ==");
         $finish;
      end
   end

   task automatic send_request(input logic op, input logic [ROW_W-1:0] row,
                               input vmt_pkg::vmt_word_type c0,
                               input vmt_pkg::vmt_word_type c1,
                               input vmt_pkg::vmt_word_type c2,
                               input vmt_pkg::vmt_word_type c3);
      vmt_pkg::vmt_req_type item;
      item.operation = op;
      item.row_index = row;
      item.comp_0    = c0;
      item.comp_1    = c1;
      item.comp_2    = c2;
      item.comp_3    = c3;
      while ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
   endtask

   function automatic vmt_pkg::vmt_word_type random_word();
      case ($urandom_range(4))
         0: return $urandom;
         1: return $urandom_range(32'h0008_0000) - 32'h0004_0000;
         2: return $urandom_range(32'h0200_0000) - 32'h0100_0000;
         3: return $urandom_range(32'h0000_0100) - 32'h0000_0080;
         default: begin
            case ($urandom_range(5))
               0: return 32'h0000_0000;
               1: return 32'h0001_0000;
               2: return 32'hFFFF_FFFF;
               3: return 32'h7FFF_FFFF;
               4: return 32'h8000_0000;
               default: return 32'hFFFF_0000;
            endcase
         end
      endcase
   endfunction

   task automatic send_random_load(input logic [ROW_W-1:0] row);
      send_request(vmt_pkg::OP_LOAD, row, random_word(), random_word(), random_word(),
                   random_word());
   endtask

   task automatic send_random_transform();
      send_request(vmt_pkg::OP_TRANSFORM, ROW_W'($urandom_range(3)), random_word(),
                   random_word(), random_word(), random_word());
   endtask

   task automatic test_directed_cases();
      send_gap_pct  = 7;
      rsp_stall_pct = 7;
      // The matrix is zero after reset.
      send_request(vmt_pkg::OP_TRANSFORM, 2'd0, 32'h7FFF_FFFF, 32'h8000_0000,
                   32'hFFFF_FFFF, 32'h1);
      for (int r = 0; r < 4; r++) begin
         send_request(vmt_pkg::OP_LOAD, ROW_W'(r), (r == 0) ? 32'h0001_0000 : 32'h0,
                      (r == 1) ? 32'h0001_0000 : 32'h0, (r == 2) ? 32'h0001_0000 : 32'h0,
                      (r == 3) ? 32'h0001_0000 : 32'h0);
      end
      send_request(vmt_pkg::OP_TRANSFORM, 2'd3, 32'h7FFF_FFFF, 32'h8000_0000,
                   32'hFFFF_FFFF, 32'h0);
      send_request(vmt_pkg::OP_TRANSFORM, 2'd1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0,
                   32'hFFFF_FFFF);
      for (int r = 0; r < 4; r++) begin
         send_request(vmt_pkg::OP_LOAD, ROW_W'(r), 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                      32'h7FFF_FFFF, 32'h7FFF_FFFF);
      end
      send_request(vmt_pkg::OP_TRANSFORM, 2'd2, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                   32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_request(vmt_pkg::OP_TRANSFORM, 2'd0, 32'h8000_0000, 32'h8000_0000,
                   32'h8000_0000, 32'h8000_0000);
      for (int r = 0; r < 4; r++) begin
         send_request(vmt_pkg::OP_LOAD, ROW_W'(r), 32'h8000_0000, 32'h8000_0000,
                      32'h8000_0000, 32'h8000_0000);
      end
      // Four products of -2^31 by -2^31 sum past the 64-bit range.
      send_request(vmt_pkg::OP_TRANSFORM, 2'd0, 32'h8000_0000, 32'h8000_0000,
                   32'h8000_0000, 32'h8000_0000);
      send_request(vmt_pkg::OP_TRANSFORM, 2'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                   32'hFFFF_FFFF, 32'hFFFF_FFFF);
      // A tiny negative product must round toward minus infinity.
      send_request(vmt_pkg::OP_LOAD, 2'd0, 32'h1, 32'h1, 32'h1, 32'h1);
      send_request(vmt_pkg::OP_TRANSFORM, 2'd2, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0);
   endtask

   task automatic test_random_streams();
      int gap_table   [4] = '{0, 46, 0, 7};
      int stall_table [4] = '{0, 0, 46, 7};
      for (int p = 0; p < 4; p++) begin
         send_gap_pct  = gap_table[p];
         rsp_stall_pct = stall_table[p];
         for (int n = 0; n < 270; n++) begin
            case ($urandom_range(19))
               0: begin
                  for (int r = 0; r < 4; r++) begin
                     send_random_load(ROW_W'(r));
                  end
                  n += 3;
               end
               1, 2, 3: send_random_load(ROW_W'($urandom_range(3)));
               default: send_random_transform();
            endcase
         end
      end
   endtask

   task automatic test_backpressure();
      send_gap_pct  = 0;
      rsp_stall_pct = 0;
      req_valid    <= 1'b0;
      @(negedge clock);
      hold_left = 150;
      @(posedge clock);
      send_random_load(ROW_W'($urandom_range(3)));
      for (int n = 0; n < 60; n++) begin
         send_random_transform();
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_cases();
      test_random_streams();
      test_backpressure();
      req_valid     <= 1'b0;
      rsp_stall_pct = 0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
